// File: rtl/core/asmc_pkg.sv
// Package for the compute-instruction encoder: parse state type, codes and mnemonic tables.
package asmc_pkg;

  // Parse phases.
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_COMP  = 2'd1;
  localparam logic [1:0] PH_JUMP  = 2'd2;

  // Error codes, in the order they are checked.
  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_COMP = 2'd1;
  localparam logic [1:0] ERR_DEST = 2'd2;
  localparam logic [1:0] ERR_JUMP = 2'd3;

  // Separator characters.
  localparam logic [7:0] CH_EQ   = 8'h3D;  // '='
  localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'

  // Each part keeps its first three characters and a count that saturates at seven.
  localparam int unsigned SEG_CHARS = 3;
  localparam logic [2:0]  LEN_MAX   = 3'd7;

  typedef logic [SEG_CHARS-1:0][7:0] seg_t;

  typedef struct packed {
    logic [1:0] phase;
    seg_t       first_seg;
    logic [2:0] first_len;
    seg_t       comp_seg;
    logic [2:0] comp_len;
    seg_t       jump_seg;
    logic [2:0] jump_len;
    logic       have_dest;
  } parse_st_t;

  // Returns {hit, a, c1..c6}. Only the first len characters take part.
  function automatic logic [7:0] comp_lookup(input seg_t seg, input logic [1:0] len);
    logic [7:0] res;
    res = '0;
    unique case (len)
      2'd1: begin
        unique case (seg[0])
          "0":     res = {1'b1, 7'h2A};
          "1":     res = {1'b1, 7'h3F};
          "D":     res = {1'b1, 7'h0C};
          "A":     res = {1'b1, 7'h30};
          "M":     res = {1'b1, 7'h70};
          default: res = '0;
        endcase
      end
      2'd2: begin
        unique case ({seg[0], seg[1]})
          "-1":    res = {1'b1, 7'h3A};
          "!D":    res = {1'b1, 7'h0D};
          "!A":    res = {1'b1, 7'h31};
          "!M":    res = {1'b1, 7'h71};
          "-D":    res = {1'b1, 7'h0F};
          "-A":    res = {1'b1, 7'h33};
          "-M":    res = {1'b1, 7'h73};
          default: res = '0;
        endcase
      end
      2'd3: begin
        unique case ({seg[0], seg[1], seg[2]})
          "D+1":        res = {1'b1, 7'h1F};
          "A+1":        res = {1'b1, 7'h37};
          "M+1":        res = {1'b1, 7'h77};
          "D-1":        res = {1'b1, 7'h0E};
          "A-1":        res = {1'b1, 7'h32};
          "M-1":        res = {1'b1, 7'h72};
          "D+A", "A+D": res = {1'b1, 7'h02};
          "D+M", "M+D": res = {1'b1, 7'h42};
          "D-A":        res = {1'b1, 7'h13};
          "D-M":        res = {1'b1, 7'h53};
          "A-D":        res = {1'b1, 7'h07};
          "M-D":        res = {1'b1, 7'h47};
          "D&A", "A&D": res = {1'b1, 7'h00};
          "D&M", "M&D": res = {1'b1, 7'h40};
          "D|A", "A|D": res = {1'b1, 7'h15};
          "D|M", "M|D": res = {1'b1, 7'h55};
          default:      res = '0;
        endcase
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // Returns {hit, d1 d2 d3}; the destination must be one to three characters.
  function automatic logic [3:0] dest_lookup(input seg_t seg, input logic [2:0] len);
    logic [3:0] res;
    res = '0;
    unique case (len)
      3'd1: begin
        unique case (seg[0])
          "M":     res = {1'b1, 3'd1};
          "D":     res = {1'b1, 3'd2};
          "A":     res = {1'b1, 3'd4};
          default: res = '0;
        endcase
      end
      3'd2: begin
        unique case ({seg[0], seg[1]})
          "MD":    res = {1'b1, 3'd3};
          "AM":    res = {1'b1, 3'd5};
          "AD":    res = {1'b1, 3'd6};
          default: res = '0;
        endcase
      end
      3'd3: begin
        res = ({seg[0], seg[1], seg[2]} == "AMD") ? {1'b1, 3'd7} : 4'd0;
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // Returns {hit, j1 j2 j3}; the jump must be exactly three characters.
  function automatic logic [3:0] jump_lookup(input seg_t seg, input logic [2:0] len);
    logic [3:0] res;
    res = '0;
    if (len == 3'd3) begin
      unique case ({seg[0], seg[1], seg[2]})
        "JGT":   res = {1'b1, 3'd1};
        "JEQ":   res = {1'b1, 3'd2};
        "JGE":   res = {1'b1, 3'd3};
        "JLT":   res = {1'b1, 3'd4};
        "JNE":   res = {1'b1, 3'd5};
        "JLE":   res = {1'b1, 3'd6};
        "JMP":   res = {1'b1, 3'd7};
        default: res = '0;
      endcase
    end
    return res;
  endfunction

endpackage

// File: rtl/core/asm_c_instruction_encoder.sv
// Top level of the compute-instruction encoder: character intake, parse state, result register.
//
// The block takes the text of one compute instruction, dest=comp;jump, one ASCII
// character per transfer on the input channel, with last set on the final character,
// and gives one result transfer per instruction: the 16-bit encoded word and a
// 2-bit error code (0 ok, 1 bad comp, 2 bad dest, 3 bad jump, checked in that order;
// the word is zero on any error). A character is taken in every cycle in which the
// result register is empty or its result is being taken in that cycle, so the
// sustained rate is one character per clock. The result of an instruction appears
// in the cycle after its last character is accepted: the parse state update and the
// mnemonic table compares are one level of logic feeding the result register, and
// that register is the only stage between the two channels. Non-last characters
// give no result. After the last character the parse state returns to its reset
// value, ready for the next instruction. Reset is synchronous and active high.
module asm_c_instruction_encoder
  import asmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] word,
  output logic [1:0]  error
);

  parse_st_t   st;
  parse_st_t   st_next;
  logic        in_xfer;
  logic [15:0] enc_word;
  logic [1:0]  enc_error;

  // The result register frees up in the same cycle its content is taken.
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // Fold the incoming character into the parse state. The first separator splits the
  // text and a ';' after that '=' splits it again; later separators are ordinary characters of their part.
  always_comb begin
    st_next = st;
    unique case (st.phase)
      PH_FIRST: begin
        if (ch == CH_EQ) begin
          st_next.have_dest = 1'b1;
          st_next.phase     = PH_COMP;
        end else if (ch == CH_SEMI) begin
          // No '=': what came so far is the comp part.
          st_next.comp_seg = st.first_seg;
          st_next.comp_len = st.first_len;
          st_next.phase    = PH_JUMP;
        end else begin
          if (st.first_len < 3'd3) begin
            st_next.first_seg[st.first_len[1:0]] = ch;
          end
          if (st.first_len != LEN_MAX) begin
            st_next.first_len = st.first_len + 3'd1;
          end
        end
      end
      PH_COMP: begin
        if (ch == CH_SEMI) begin
          st_next.phase = PH_JUMP;
        end else begin
          if (st.comp_len < 3'd3) begin
            st_next.comp_seg[st.comp_len[1:0]] = ch;
          end
          if (st.comp_len != LEN_MAX) begin
            st_next.comp_len = st.comp_len + 3'd1;
          end
        end
      end
      default: begin
        if (st.jump_len < 3'd3) begin
          st_next.jump_seg[st.jump_len[1:0]] = ch;
        end
        if (st.jump_len != LEN_MAX) begin
          st_next.jump_len = st.jump_len + 3'd1;
        end
      end
    endcase
  end

  // The encoder looks at the state that includes the final character.
  asmc_encode u_encode (
    .st    (st_next),
    .word  (enc_word),
    .error (enc_error)
  );

  // Parse state: cleared by reset and after each final character.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_xfer) begin
      if (last) begin
        st <= '0;
      end else begin
        st <= st_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && last) begin
      word  <= enc_word;
      error <= enc_error;
    end
  end

endmodule

// File: rtl/core/asmc_encode.sv
// Builds the 16-bit word and error code from a completed parse state.
module asmc_encode
  import asmc_pkg::*;
(
  input  parse_st_t   st,
  output logic [15:0] word,
  output logic [1:0]  error
);

  seg_t       cs;
  logic [2:0] cl;
  logic [1:0] ceff;
  logic [7:0] comp_hit;
  logic [3:0] dest_hit;
  logic [3:0] jump_hit;
  logic       jump_part;
  logic [2:0] dest_bits;
  logic [2:0] jump_bits;

  // Without any separator the comp text is still in the first segment.
  assign cs   = (st.phase == PH_FIRST) ? st.first_seg : st.comp_seg;
  assign cl   = (st.phase == PH_FIRST) ? st.first_len : st.comp_len;
  assign ceff = (cl > 3'd3) ? 2'd3 : cl[1:0];

  assign comp_hit  = comp_lookup(cs, ceff);
  assign dest_hit  = dest_lookup(st.first_seg, st.first_len);
  assign jump_hit  = jump_lookup(st.jump_seg, st.jump_len);
  assign jump_part = st.phase[1];

  assign dest_bits = st.have_dest ? dest_hit[2:0] : 3'd0;
  assign jump_bits = jump_part ? jump_hit[2:0] : 3'd0;

  always_comb begin
    priority if (!comp_hit[7]) begin
      error = ERR_COMP;
    end else if (st.have_dest && !dest_hit[3]) begin
      error = ERR_DEST;
    end else if (jump_part && !jump_hit[3]) begin
      error = ERR_JUMP;
    end else begin
      error = ERR_OK;
    end
  end

  assign word = (error == ERR_OK) ? {3'b111, comp_hit[6:0], dest_bits, jump_bits} : 16'd0;

endmodule

// File: rtl/core/asmc_checker.sv
// Port-level checks for the compute-instruction encoder and their binding to the top level.
module asmc_checker
  import asmc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] word,
  input logic [1:0]  error
);

  // A failed instruction never shows a nonzero word.
  a_err_zero_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (error != ERR_OK)) |-> (word == 16'd0))
    else $error("nonzero word with an error code");

  // A good instruction always carries the compute prefix.
  a_ok_prefix: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (error == ERR_OK)) |-> (word[15:13] == 3'b111))
    else $error("good result without the compute prefix");

  // A final character yields a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last) |=> out_valid)
    else $error("no result after the final character");

  // Any other character yields none.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !last) |=> !out_valid)
    else $error("result after a character that is not final");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(word) && $stable(error)))
    else $error("stalled result changed");

endmodule

bind asm_c_instruction_encoder asmc_checker u_asmc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .last      (last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .word      (word),
  .error     (error)
);

// File: tb/sv/tb_asm_c_instruction_encoder.sv
`timescale 1ns / 1ps
// Testbench for the compute-instruction encoder: directed and random instruction text checked against a predictor.
module tb_asm_c_instruction_encoder;
  import asmc_pkg::*;

  // A receiver hold-off of this many cycles is far longer than it takes the single
  // result register to fill, so the input channel is forced to stall.
  localparam int unsigned HOLD_CYCLES = 200;
  // Cycles with no transfer on either channel before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned CHAR_TARGET = 1400;
  localparam int unsigned IDLE_PCT    = 28;
  // The result shows up in the cycle after the last character is taken, so a short tail is plenty.
  localparam int unsigned TAIL_CYCLES = 8;

  typedef struct packed {
    logic [15:0] word;
    logic [1:0]  error;
  } enc_result_t;

  // One row of the directed table. Text is right-aligned, first character in the
  // highest byte that is in use. Rows marked typed carry their expected error by
  // hand (the word is zero); all others are checked against the predictor.
  typedef struct packed {
    logic [95:0] text;
    logic [3:0]  len;
    logic        typed;
    logic [1:0]  err;
  } text_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  ch        = 8'h00;
  logic        last      = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] word;
  logic [1:0]  error;

  always #2 clk = ~clk;

  asm_c_instruction_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .word      (word),
    .error     (error)
  );

  // Mnemonic tables of the assembly language. Comp values hold the a bit on top
  // of c1..c6; dest and jump codes are the table index, with index 0 unused.
  string comp_names[34] = '{
    "0", "1", "-1", "D", "A", "M", "!D", "!A", "!M", "-D", "-A", "-M",
    "D+1", "A+1", "M+1", "D-1", "A-1", "M-1", "D+A", "A+D", "D+M", "M+D",
    "D-A", "D-M", "A-D", "M-D", "D&A", "A&D", "D&M", "M&D", "D|A", "A|D",
    "D|M", "M|D"
  };
  logic [6:0] comp_vals[34] = '{
    7'h2A, 7'h3F, 7'h3A, 7'h0C, 7'h30, 7'h70, 7'h0D, 7'h31, 7'h71, 7'h0F, 7'h33, 7'h73,
    7'h1F, 7'h37, 7'h77, 7'h0E, 7'h32, 7'h72, 7'h02, 7'h02, 7'h42, 7'h42,
    7'h13, 7'h53, 7'h07, 7'h47, 7'h00, 7'h00, 7'h40, 7'h40, 7'h15, 7'h15,
    7'h55, 7'h55
  };
  string dest_names[8] = '{"", "M", "D", "MD", "A", "AM", "AD", "AMD"};
  string jump_names[8] = '{"", "JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};

  // Predictor copy of the parse state.
  logic [1:0] p_phase;
  seg_t       p_first, p_comp, p_jump;
  logic [2:0] p_first_len, p_comp_len, p_jump_len;
  logic       p_have_dest;

  // Results still owed by the block, oldest first.
  enc_result_t expected_codes[$];

  int unsigned chars_sent    = 0;
  int unsigned fail_count    = 0;
  int unsigned idle_pct      = IDLE_PCT;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  function automatic void clear_parse();
    p_phase     = PH_FIRST;
    p_first     = '0;
    p_comp      = '0;
    p_jump      = '0;
    p_first_len = '0;
    p_comp_len  = '0;
    p_jump_len  = '0;
    p_have_dest = 1'b0;
  endfunction

  // Keeps the first three characters of a part; the count saturates.
  function automatic void add_char(inout seg_t s, inout logic [2:0] n, input logic [7:0] c);
    if (n < 3'd3) s[n[1:0]] = c;
    if (n != LEN_MAX) n = n + 3'd1;
  endfunction

  // Turns the kept characters into a string for table lookup. A NUL cannot live in
  // a string, so it is replaced by a character that no mnemonic contains.
  function automatic string seg_text(input seg_t s, input int unsigned n);
    string t;
    logic [7:0] c;
    t = "";
    for (int i = 0; i < n; i++) begin
      c = s[i];
      if (c == 8'h00) c = "?";
      t = $sformatf("%s%c", t, c);
    end
    return t;
  endfunction

  // Advances the predictor by one character. Returns 1 and the encoding when the
  // character closes an instruction.
  function automatic bit encode_char(input logic [7:0] c, input logic l, output enc_result_t r);
    seg_t        cs;
    int unsigned cl;
    logic [6:0]  comp_bits;
    logic [2:0]  dest_bits, jump_bits;
    logic [1:0]  code;
    string       t;
    bit          hit;
    r = '0;
    case (p_phase)
      PH_FIRST: begin
        if (c == CH_EQ) begin
          p_have_dest = 1'b1;
          p_phase     = PH_COMP;
        end else if (c == CH_SEMI) begin
          // No dest: what was collected so far is the comp part.
          p_comp     = p_first;
          p_comp_len = p_first_len;
          p_phase    = PH_JUMP;
        end else begin
          add_char(p_first, p_first_len, c);
        end
      end
      PH_COMP: begin
        if (c == CH_SEMI) p_phase = PH_JUMP;
        else add_char(p_comp, p_comp_len, c);
      end
      default: add_char(p_jump, p_jump_len, c);
    endcase
    if (!l) return 1'b0;

    if (p_phase == PH_FIRST) begin
      cs = p_first;
      cl = p_first_len;
    end else begin
      cs = p_comp;
      cl = p_comp_len;
    end
    code      = ERR_OK;
    comp_bits = '0;
    dest_bits = '0;
    jump_bits = '0;

    // Only the first three comp characters are compared; anything longer is ignored.
    hit = 1'b0;
    if (cl != 0) begin
      t = seg_text(cs, (cl > 3) ? 3 : cl);
      foreach (comp_names[k]) begin
        if (!hit && comp_names[k] == t) begin
          comp_bits = comp_vals[k];
          hit       = 1'b1;
        end
      end
    end
    if (!hit) code = ERR_COMP;

    if (code == ERR_OK && p_have_dest) begin
      hit = 1'b0;
      if (p_first_len >= 3'd1 && p_first_len <= 3'd3) begin
        t = seg_text(p_first, p_first_len);
        for (int k = 1; k < 8; k++) begin
          if (!hit && dest_names[k] == t) begin
            dest_bits = 3'(k);
            hit       = 1'b1;
          end
        end
      end
      if (!hit) code = ERR_DEST;
    end

    // A jump needs exactly three characters after the semicolon.
    if (code == ERR_OK && p_phase >= PH_JUMP) begin
      hit = 1'b0;
      if (p_jump_len == 3'd3) begin
        t = seg_text(p_jump, 3);
        for (int k = 1; k < 8; k++) begin
          if (!hit && jump_names[k] == t) begin
            jump_bits = 3'(k);
            hit       = 1'b1;
          end
        end
      end
      if (!hit) code = ERR_JUMP;
    end

    r.error = code;
    r.word  = (code == ERR_OK) ? {3'b111, comp_bits, dest_bits, jump_bits} : 16'h0000;
    clear_parse();
    return 1'b1;
  endfunction

  // Offers one character, with random idle cycles first, and waits for its transfer.
  // The expectation is queued at the transfer edge, before the result can appear.
  task automatic send_char(input logic [7:0] c, input logic l, input logic typed,
                           input logic [1:0] err);
    enc_result_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    last     <= l;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    if (encode_char(c, l, r)) begin
      if (typed) begin
        r.word  = 16'h0000;
        r.error = err;
      end
      expected_codes.push_back(r);
    end
  endtask

  // Drops valid and waits until the block owes nothing.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_codes.size() != 0) @(negedge clk);
  endtask

  // Three times in ten a separator or mnemonic letter, so that mutations stay interesting;
  // otherwise any byte at all.
  function automatic logic [7:0] random_char();
    string pick;
    pick = "=;AMDJ";
    if ($urandom_range(0, 9) < 3) return pick[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Most instructions are well formed with random parts; some are broken by one
  // changed, dropped or inserted character, and the rest are random bytes.
  task automatic send_random_instr();
    logic [7:0]  txt[$];
    string       s;
    int unsigned kind, pos;
    kind = $urandom_range(0, 99);
    if (kind < 82) begin
      s = comp_names[$urandom_range(0, 33)];
      if ($urandom_range(0, 19) == 0) s = {s, "D1"};
      if ($urandom_range(0, 9) < 7) s = {dest_names[$urandom_range(1, 7)], "=", s};
      if ($urandom_range(0, 9) < 6) s = {s, ";", jump_names[$urandom_range(1, 7)]};
      for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
      if (kind >= 66) begin
        pos = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 2))
          0: txt[pos] = random_char();
          1: txt.delete(pos);
          default: txt.insert(pos, random_char());
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 9)) txt.push_back(random_char());
    end
    if (txt.size() == 0) txt.push_back(random_char());
    foreach (txt[i]) send_char(txt[i], i == txt.size() - 1, 1'b0, ERR_OK);
  endtask

  // Receiver: random ready, except during a requested hold-off, which this process
  // counts out on its own while the sender keeps offering characters.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      out_ready    <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Each result transfer is matched against the oldest owed result.
  always @(posedge clk) begin
    enc_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_codes.size() == 0) begin
        $display("%0t: result with nothing owed, word %h error %0d", $time, word, error);
        fail_count++;
      end else begin
        exp_r = expected_codes.pop_front();
        if (word !== exp_r.word) begin
          $display("%0t: word mismatch, expected %h, got %h", $time, exp_r.word, word);
          fail_count++;
        end
        if (error !== exp_r.error) begin
          $display("%0t: error mismatch, expected %0d, got %0d", $time, exp_r.error, error);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any transfer on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    text_row_t   directed_rows[15];
    int unsigned n, n_instr;
    clear_parse();

    // Well-formed forms first, then each way an instruction can go wrong, with a case
    // for the order the block ranks its errors, and the extreme character codes.
    directed_rows = '{
      '{"D=M",         4'd3,  1'b0, ERR_OK},
      '{"0;JMP",       4'd5,  1'b0, ERR_OK},
      '{"AMD=D+1;JGT", 4'd11, 1'b0, ERR_OK},
      '{"A=!M",        4'd4,  1'b0, ERR_OK},
      '{"D+1XYZ",      4'd6,  1'b0, ERR_OK},    // comp longer than three characters
      '{";JMP",        4'd4,  1'b1, ERR_COMP},  // empty comp
      '{"=D",          4'd2,  1'b1, ERR_DEST},  // empty dest
      '{"AMDM=D",      4'd6,  1'b1, ERR_DEST},  // dest too long
      '{"D;",          4'd2,  1'b1, ERR_JUMP},  // empty jump
      '{"D;JMPX",      4'd6,  1'b1, ERR_JUMP},  // jump too long
      '{"D=M=1",       4'd5,  1'b1, ERR_COMP},  // second '=' belongs to comp
      '{"D;J;P",       4'd5,  1'b1, ERR_JUMP},  // second ';' belongs to jump
      '{"X=Q;JQQ",     4'd7,  1'b1, ERR_COMP},  // comp is ranked before dest and jump
      '{{8'h00, ";JMP"}, 4'd5, 1'b1, ERR_COMP},
      '{{"M=", 8'hFF},   4'd3, 1'b1, ERR_COMP}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      n = directed_rows[r].len;
      for (int i = 0; i < n; i++)
        send_char(directed_rows[r].text[8 * (n - 1 - i) +: 8], i == n - 1,
                  directed_rows[r].typed, directed_rows[r].err);
    end

    // Random instructions, with one receiver hold-off, one full drain, and a
    // stretch where neither side idles.
    n_instr = 0;
    while (chars_sent < CHAR_TARGET) begin
      if (n_instr == 40) hold_requests++;
      if (n_instr == 90) idle_pct = 0;
      if (n_instr == 150) idle_pct = IDLE_PCT;
      if (n_instr == 170) drain_results();
      send_random_instr();
      n_instr++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
